// ----- hdl/rational_arith_unit_core_assert.svh -----
// Assertion macros used by the top RTL file of the rational arithmetic unit.
`ifndef RATIONAL_ARITH_UNIT_CORE_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define RAU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rau_pkg.sv -----
`default_nettype none

package rau_pkg;

    localparam int OPERAND_BITS = 16;
    localparam int PROD_BITS    = 2 * OPERAND_BITS;
    localparam int MAG_BITS     = PROD_BITS + 1;
    localparam int SHIFT_BITS   = $clog2(MAG_BITS + 1);
    localparam int GCD_STEPS    = 2 * MAG_BITS;
    localparam int NUM_BITS     = 33;
    localparam int DEN_BITS     = 31;
    localparam int FIELD_BITS   = 16;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_DIV_ZERO = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                          cmd;
        logic signed [FIELD_BITS-1:0]  lhs_num;
        logic signed [FIELD_BITS-1:0]  lhs_den;
        logic signed [FIELD_BITS-1:0]  rhs_num;
        logic signed [FIELD_BITS-1:0]  rhs_den;
    } t_in;

    typedef struct packed {
        logic signed [NUM_BITS-1:0] res_num;
        logic [DEN_BITS-1:0]        res_den;
        t_status                    status;
    } t_out;

    typedef struct packed {
        t_status               status;
        logic                  neg;
        logic                  zero;
        logic [MAG_BITS-1:0]   a;
        logic [MAG_BITS-1:0]   b;
        logic [MAG_BITS-1:0]   n;
        logic [MAG_BITS-1:0]   d;
        logic [SHIFT_BITS-1:0] k;
    } t_stage;

    typedef struct packed {
        t_status             status;
        logic                neg;
        logic                zero;
        logic [MAG_BITS-1:0] dvs;
        logic [MAG_BITS:0]   rn;
        logic [MAG_BITS-1:0] qn;
        logic [MAG_BITS:0]   rd;
        logic [MAG_BITS-1:0] qd;
    } t_div;

endpackage

`default_nettype wire

// ----- hdl/rau_front.sv -----
`default_nettype none

module rau_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  rau_pkg::t_in   i_data,
    output logic           o_valid,
    output rau_pkg::t_stage o_stage
);
    import rau_pkg::*;

    typedef struct packed {
        t_status              status;
        logic                 s1;
        logic                 s2;
        logic                 dneg;
        logic [PROD_BITS-1:0] p1;
        logic [PROD_BITS-1:0] p2;
        logic [PROD_BITS-1:0] p3;
    } t_prod;

    function automatic logic [OPERAND_BITS-1:0] mag(input logic [OPERAND_BITS-1:0] v);
        return v[OPERAND_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    t_prod  r_prod, n_prod;
    logic   r_prod_vld;
    t_stage r_stage, n_stage;
    logic   r_stage_vld;

    always_comb begin
        logic [OPERAND_BITS-1:0] ln, ld, rn, rd, mb, mc;
        logic sln, sld, srn, srd;
        ln  = mag(OPERAND_BITS'(i_data.lhs_num));
        ld  = mag(OPERAND_BITS'(i_data.lhs_den));
        rn  = mag(OPERAND_BITS'(i_data.rhs_num));
        rd  = mag(OPERAND_BITS'(i_data.rhs_den));
        sln = i_data.lhs_num[OPERAND_BITS-1];
        sld = i_data.lhs_den[OPERAND_BITS-1];
        srn = i_data.rhs_num[OPERAND_BITS-1];
        srd = i_data.rhs_den[OPERAND_BITS-1];
        if (ld == '0 || rd == '0) begin
            n_prod.status = ST_INVALID;
        end else if (i_data.cmd == CMD_DIV && rn == '0) begin
            n_prod.status = ST_DIV_ZERO;
        end else begin
            n_prod.status = ST_OK;
        end
        mb = (i_data.cmd == CMD_MUL) ? rn : rd;
        mc = (i_data.cmd == CMD_DIV) ? rn : rd;
        n_prod.p1 = PROD_BITS'(ln) * PROD_BITS'(mb);
        n_prod.p3 = PROD_BITS'(ld) * PROD_BITS'(mc);
        n_prod.s1 = sln ^ ((i_data.cmd == CMD_MUL) ? srn : srd);
        n_prod.dneg = sld ^ ((i_data.cmd == CMD_DIV) ? srn : srd);
        if (i_data.cmd == CMD_ADD || i_data.cmd == CMD_SUB) begin
            n_prod.p2 = PROD_BITS'(rn) * PROD_BITS'(ld);
            n_prod.s2 = srn ^ sld ^ (i_data.cmd == CMD_SUB);
        end else begin
            n_prod.p2 = '0;
            n_prod.s2 = n_prod.s1;
        end
    end

    always_comb begin
        logic [MAG_BITS-1:0] nmag;
        logic                nneg;
        priority if (r_prod.s1 == r_prod.s2) begin
            nmag = MAG_BITS'(r_prod.p1) + MAG_BITS'(r_prod.p2);
            nneg = r_prod.s1;
        end else if (r_prod.p1 >= r_prod.p2) begin
            nmag = MAG_BITS'(r_prod.p1 - r_prod.p2);
            nneg = r_prod.s1;
        end else begin
            nmag = MAG_BITS'(r_prod.p2 - r_prod.p1);
            nneg = r_prod.s2;
        end
        n_stage.status = r_prod.status;
        n_stage.neg    = nneg ^ r_prod.dneg;
        n_stage.zero   = (nmag == '0) || (r_prod.status != ST_OK);
        n_stage.a      = nmag;
        n_stage.b      = MAG_BITS'(r_prod.p3);
        n_stage.n      = nmag;
        n_stage.d      = MAG_BITS'(r_prod.p3);
        n_stage.k      = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld  <= 1'b0;
            r_stage_vld <= 1'b0;
        end else if (i_en) begin
            r_prod_vld  <= i_valid;
            r_stage_vld <= r_prod_vld;
        end
        if (i_en) begin
            r_prod  <= n_prod;
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_stage_vld;
    assign o_stage = r_stage;

endmodule

`default_nettype wire

// ----- hdl/rau_gcd.sv -----
`default_nettype none

module rau_gcd (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  rau_pkg::t_stage i_stage,
    output logic            o_valid,
    output rau_pkg::t_stage o_stage
);
    import rau_pkg::*;

    function automatic t_stage gstep(input t_stage s);
        t_stage r;
        r = s;
        if (s.a != '0 && s.b != '0) begin
            priority if (!s.a[0] && !s.b[0]) begin
                r.a = s.a >> 1;
                r.b = s.b >> 1;
                r.k = SHIFT_BITS'(s.k + 1'b1);
            end else if (!s.a[0]) begin
                r.a = s.a >> 1;
            end else if (!s.b[0]) begin
                r.b = s.b >> 1;
            end else if (s.a >= s.b) begin
                r.a = (s.a - s.b) >> 1;
            end else begin
                r.b = (s.b - s.a) >> 1;
            end
        end
        return r;
    endfunction

    t_stage w_st  [GCD_STEPS+1];
    logic   w_vld [GCD_STEPS+1];

    assign w_st[0]  = i_stage;
    assign w_vld[0] = i_valid;

    for (genvar i = 0; i < GCD_STEPS; i++) begin : g_step
        t_stage r_st;
        logic   r_vld;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[i];
            end
            if (i_en) begin
                r_st <= gstep(w_st[i]);
            end
        end
        assign w_st[i+1]  = r_st;
        assign w_vld[i+1] = r_vld;
    end

    assign o_valid = w_vld[GCD_STEPS];
    assign o_stage = w_st[GCD_STEPS];

endmodule

`default_nettype wire

// ----- hdl/rau_div.sv -----
`default_nettype none

module rau_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  rau_pkg::t_stage i_stage,
    output logic            o_valid,
    output rau_pkg::t_div   o_div
);
    import rau_pkg::*;

    function automatic t_div dstep(input t_div s);
        t_div r;
        logic [MAG_BITS:0] tn, td;
        r    = s;
        tn   = {s.rn[MAG_BITS-1:0], s.qn[MAG_BITS-1]};
        td   = {s.rd[MAG_BITS-1:0], s.qd[MAG_BITS-1]};
        r.qn = {s.qn[MAG_BITS-2:0], 1'b0};
        r.qd = {s.qd[MAG_BITS-2:0], 1'b0};
        if (tn >= {1'b0, s.dvs}) begin
            tn      = tn - {1'b0, s.dvs};
            r.qn[0] = 1'b1;
        end
        if (td >= {1'b0, s.dvs}) begin
            td      = td - {1'b0, s.dvs};
            r.qd[0] = 1'b1;
        end
        r.rn = tn;
        r.rd = td;
        return r;
    endfunction

    t_div w_dv  [MAG_BITS+1];
    logic w_vld [MAG_BITS+1];
    t_div r_init, n_init;
    logic r_init_vld;

    always_comb begin
        n_init.status = i_stage.status;
        n_init.neg    = i_stage.neg;
        n_init.zero   = i_stage.zero;
        n_init.dvs    = i_stage.a | i_stage.b;
        n_init.rn     = '0;
        n_init.qn     = i_stage.n >> i_stage.k;
        n_init.rd     = '0;
        n_init.qd     = i_stage.d >> i_stage.k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_vld <= 1'b0;
        end else if (i_en) begin
            r_init_vld <= i_valid;
        end
        if (i_en) begin
            r_init <= n_init;
        end
    end

    assign w_dv[0]  = r_init;
    assign w_vld[0] = r_init_vld;

    for (genvar i = 0; i < MAG_BITS; i++) begin : g_bit
        t_div r_dv;
        logic r_vld;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[i];
            end
            if (i_en) begin
                r_dv <= dstep(w_dv[i]);
            end
        end
        assign w_dv[i+1]  = r_dv;
        assign w_vld[i+1] = r_vld;
    end

    assign o_valid = w_vld[MAG_BITS];
    assign o_div   = w_dv[MAG_BITS];

endmodule

`default_nettype wire

// ----- hdl/rational_arith_unit_core.sv -----
// Rational arithmetic unit: adds, subtracts, multiplies or divides two
// fractions and returns the result in lowest terms with a positive denominator.
// The input channel (i_valid, o_stall, i_data) takes one item per transfer;
// the output channel (o_valid, i_stall, o_data) returns exactly one result per
// item, in order. A zero denominator gives status invalid, a divide by a zero
// right operand gives status division by zero, and both give 0/1.
// The block is a pipeline: a products stage and a sum stage, 66 binary gcd
// steps, a shift stage, 33 restoring division steps and an output register.
// A new item can be taken in every cycle in which o_stall is low, so the
// sustained rate is one item per cycle while the receiver does not stall;
// the latency is set by the gcd step chain and the divider chain.
// Reset clears every valid bit and the pipeline comes out empty.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_stall rises, so no item is lost or repeated; it moves again once the
// result is taken.
`default_nettype none
`include "rational_arith_unit_core_assert.svh"

module rational_arith_unit_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rau_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output rau_pkg::t_out o_data
);
    import rau_pkg::*;

    logic   adv;
    logic   front_vld, gcd_vld, div_vld;
    t_stage front_st, gcd_st;
    t_div   div_res;
    t_out   r_out, n_out;
    logic   r_out_vld;

    assign adv     = !r_out_vld || !i_stall;
    assign o_stall = !adv;

    rau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (front_vld),
        .o_stage (front_st)
    );

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (front_vld),
        .i_stage (front_st),
        .o_valid (gcd_vld),
        .o_stage (gcd_st)
    );

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (gcd_vld),
        .i_stage (gcd_st),
        .o_valid (div_vld),
        .o_div   (div_res)
    );

    always_comb begin
        n_out.status = div_res.status;
        if (div_res.zero) begin
            n_out.res_num = '0;
            n_out.res_den = DEN_BITS'(1);
        end else begin
            n_out.res_num = div_res.neg ? NUM_BITS'(0 - {1'b0, div_res.qn})
                                        : NUM_BITS'({1'b0, div_res.qn});
            n_out.res_den = DEN_BITS'(div_res.qd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= div_vld;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    `RAU_ASSERT_IMPLY(a_den_nonzero, i_clk, i_rst_n, o_valid, o_data.res_den != '0, "zero denominator")
    `RAU_ASSERT_IMPLY(a_err_is_zero, i_clk, i_rst_n, o_valid && o_data.status != ST_OK, o_data.res_num == '0 && o_data.res_den == DEN_BITS'(1), "error result not 0/1")
    `RAU_ASSERT_IMPLY(a_zero_den_one, i_clk, i_rst_n, o_valid && o_data.res_num == '0, o_data.res_den == DEN_BITS'(1), "zero result not 0/1")
    `RAU_ASSERT_NEXT(a_div_to_out, i_clk, i_rst_n, div_vld && adv, o_valid, "result lost at output")

endmodule

`default_nettype wire
